// ===== hw/rtl/dzq_pkg.sv =====
// ============================================================================
// dzq_pkg
// Shared widths, word types and register codes for the dead-zone
// quantise / dequantise unit.
// ============================================================================
package dzq_pkg;

    // Sample width and register widths
    localparam int SAMPLE_BITS = 16;
    localparam int FACTOR_W    = 18;
    localparam int OFFSET_W    = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = FACTOR_W;

    // Divider: dividend is magnitude times four
    localparam int DIVIDEND_W         = SAMPLE_BITS + 2;
    localparam int DIV_BITS_PER_STAGE = 3;
    localparam int DIV_STAGES         =
        (DIVIDEND_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;

    // Reconstruction product width and rounding term
    localparam int PROD_W      = SAMPLE_BITS + FACTOR_W;
    localparam int RECON_ROUND = 2;

    // Register reset values
    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(4);
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = '0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_X4   = CFG_IDX_W'(0),
        CFG_RECON_OFS = CFG_IDX_W'(1),
        CFG_OP_MODE   = CFG_IDX_W'(2)
    } t_cfg_reg;

    // Operating modes
    localparam logic MODE_QUANTISE   = 1'b0;
    localparam logic MODE_DEQUANTISE = 1'b1;

    // Input word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_in;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] index_out;
        logic signed [SAMPLE_BITS-1:0] recon_out;
        logic                          last_out;
    } t_out_word;

    // Configuration register set
    typedef struct packed {
        logic [FACTOR_W-1:0] step_x4;
        logic [OFFSET_W-1:0] recon_ofs;
        logic                op_mode;
    } t_cfg;

    // Sign-magnitude sideband carried alongside the divider
    typedef struct packed {
        logic                   neg;
        logic                   is_zero;
        logic                   bypass;
        logic [SAMPLE_BITS-1:0] mag;
        logic                   last;
    } t_side;

endpackage

// ===== hw/rtl/dzq_front.sv =====
// ============================================================================
// dzq_front
// Input stage: splits the sample into sign and magnitude and tags the
// word with the operating mode.
// ============================================================================
module dzq_front
    import dzq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    output logic     o_stall,
    input  logic     i_op_mode,
    output logic     o_valid,
    output t_side    o_side,
    input  logic     i_stall
);

    logic                   r_valid;
    t_side                  r_side;
    t_side                  n_side;
    logic [SAMPLE_BITS-1:0] sample_u;

    // Sign and magnitude; the most negative sample maps to 2^(N-1)
    assign sample_u = SAMPLE_BITS'(i_word.sample_in);

    always_comb begin
        n_side.neg     = sample_u[SAMPLE_BITS-1];
        n_side.mag     = n_side.neg ? (~sample_u + 1'b1) : sample_u;
        n_side.is_zero = (sample_u == '0);
        n_side.bypass  = (i_op_mode == MODE_DEQUANTISE);
        n_side.last    = i_word.last_in;
    end

    // Stage holds only when full and blocked downstream
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_side <= n_side;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;

endmodule

// ===== hw/rtl/dzq_div.sv =====
// ============================================================================
// dzq_div
// Pipelined restoring divider: (magnitude * 4) / step_x4, a few
// quotient bits per stage, sideband carried along.
// ============================================================================
module dzq_div
    import dzq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_side                 i_side,
    output logic                  o_stall,
    input  logic [FACTOR_W-1:0]   i_factor,
    output logic                  o_valid,
    output t_side                 o_side,
    output logic [DIVIDEND_W-1:0] o_quot,
    input  logic                  i_stall
);

    logic                  r_v    [DIV_STAGES];
    logic [FACTOR_W-1:0]   r_rem  [DIV_STAGES];
    logic [DIVIDEND_W-1:0] r_quo  [DIV_STAGES];
    logic [DIVIDEND_W-1:0] r_dvd  [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];
    logic                  s_stall[DIV_STAGES+1];

    assign s_stall[DIV_STAGES] = i_stall;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                  up_v;
        t_side                 up_side;
        logic [FACTOR_W-1:0]   rem_in;
        logic [DIVIDEND_W-1:0] quo_in;
        logic [DIVIDEND_W-1:0] dvd_in;
        logic [FACTOR_W-1:0]   n_rem;
        logic [DIVIDEND_W-1:0] n_quo;
        logic [DIVIDEND_W-1:0] n_dvd;
        logic [FACTOR_W:0]     trial;
        logic [FACTOR_W:0]     diff;

        // Stage input: first stage loads the dividend, others chain
        if (k == 0) begin : g_first
            assign up_v    = i_valid;
            assign up_side = i_side;
            assign rem_in  = '0;
            assign quo_in  = '0;
            assign dvd_in  = {i_side.mag, 2'b00};
        end else begin : g_next
            assign up_v    = r_v[k-1];
            assign up_side = r_side[k-1];
            assign rem_in  = r_rem[k-1];
            assign quo_in  = r_quo[k-1];
            assign dvd_in  = r_dvd[k-1];
        end

        assign s_stall[k] = r_v[k] && s_stall[k+1];

        // Shift in one dividend bit, trial subtract, per quotient bit
        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            n_dvd = dvd_in;
            trial = '0;
            diff  = '0;
            for (int t = 0; t < DIV_BITS_PER_STAGE; t++) begin
                if (k * DIV_BITS_PER_STAGE + t < DIVIDEND_W) begin
                    trial = {n_rem, n_dvd[DIVIDEND_W-1]};
                    n_dvd = n_dvd << 1;
                    diff  = trial - {1'b0, i_factor};
                    if (trial >= {1'b0, i_factor}) begin
                        n_rem = diff[FACTOR_W-1:0];
                        n_quo = {n_quo[DIVIDEND_W-2:0], 1'b1};
                    end else begin
                        n_rem = trial[FACTOR_W-1:0];
                        n_quo = {n_quo[DIVIDEND_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (!s_stall[k]) begin
                r_v[k] <= up_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!s_stall[k] && up_v) begin
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_dvd[k]  <= n_dvd;
                r_side[k] <= up_side;
            end
        end
    end

    assign o_stall = s_stall[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];
    assign o_quot  = r_quo[DIV_STAGES-1];

endmodule

// ===== hw/rtl/dzq_recon.sv =====
// ============================================================================
// dzq_recon
// Index saturation, reconstruction multiply, offset/round/shift and
// output saturation, ending in the output word register.
// ============================================================================
module dzq_recon
    import dzq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  t_side                 i_side,
    input  logic [DIVIDEND_W-1:0] i_quot,
    output logic                  o_stall,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    output t_out_word             o_word,
    input  logic                  i_stall
);

    localparam logic [DIVIDEND_W-1:0] QUO_LIM_NEG = DIVIDEND_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [DIVIDEND_W-1:0] QUO_LIM_POS = QUO_LIM_NEG - 1'b1;
    localparam logic [PROD_W-2:0]     REC_LIM_NEG = (PROD_W - 1)'(1) << (SAMPLE_BITS - 1);
    localparam logic [PROD_W-2:0]     REC_LIM_POS = REC_LIM_NEG - 1'b1;

    // Stage 1: saturated index
    logic                   r1_v;
    logic [SAMPLE_BITS-1:0] r1_imag;
    logic                   r1_neg;
    logic [SAMPLE_BITS-1:0] r1_index;
    logic                   r1_last;
    logic [SAMPLE_BITS-1:0] n1_imag;
    logic                   n1_neg;

    // Stage 2: product
    logic                   r2_v;
    logic [PROD_W-1:0]      r2_prod;
    logic                   r2_neg;
    logic                   r2_zero;
    logic [SAMPLE_BITS-1:0] r2_index;
    logic                   r2_last;

    // Stage 3: output word
    logic                   r3_v;
    t_out_word              r3_word;
    t_out_word              n3_word;
    logic [PROD_W:0]        sum;
    logic [PROD_W-2:0]      rmag;
    logic [SAMPLE_BITS-1:0] rec_mag;

    logic st1_stall;
    logic st2_stall;
    logic st3_stall;

    assign st3_stall = r3_v && i_stall;
    assign st2_stall = r2_v && st3_stall;
    assign st1_stall = r1_v && st2_stall;
    assign o_stall   = st1_stall;

    // Index magnitude: zero for a zero sample, passthrough in dequantise mode, else clamped quotient
    always_comb begin
        if (i_side.is_zero) begin
            n1_imag = '0;
        end else if (i_side.bypass) begin
            n1_imag = i_side.mag;
        end else if (i_side.neg) begin
            n1_imag = (i_quot > QUO_LIM_NEG) ? QUO_LIM_NEG[SAMPLE_BITS-1:0]
                                             : i_quot[SAMPLE_BITS-1:0];
        end else begin
            n1_imag = (i_quot > QUO_LIM_POS) ? QUO_LIM_POS[SAMPLE_BITS-1:0]
                                             : i_quot[SAMPLE_BITS-1:0];
        end
        n1_neg = i_side.neg && (n1_imag != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (!st1_stall) r1_v <= i_valid;
            if (!st2_stall) r2_v <= r1_v;
            if (!st3_stall) r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!st1_stall && i_valid) begin
            r1_imag  <= n1_imag;
            r1_neg   <= n1_neg;
            r1_index <= n1_neg ? (~n1_imag + 1'b1) : n1_imag;
            r1_last  <= i_side.last;
        end
    end

    // Reconstruction multiply
    always_ff @(posedge i_clk) begin
        if (!st2_stall && r1_v) begin
            r2_prod  <= PROD_W'(r1_imag) * PROD_W'(i_cfg.step_x4);
            r2_neg   <= r1_neg;
            r2_zero  <= (r1_imag == '0);
            r2_index <= r1_index;
            r2_last  <= r1_last;
        end
    end

    // Offset, round, shift by two, clamp; zero index reconstructs to zero
    always_comb begin
        sum  = {1'b0, r2_prod} + (PROD_W + 1)'(i_cfg.recon_ofs)
             + (PROD_W + 1)'(RECON_ROUND);
        rmag = sum[PROD_W:2];
        if (r2_neg) begin
            rec_mag = (rmag > REC_LIM_NEG) ? REC_LIM_NEG[SAMPLE_BITS-1:0]
                                           : rmag[SAMPLE_BITS-1:0];
        end else begin
            rec_mag = (rmag > REC_LIM_POS) ? REC_LIM_POS[SAMPLE_BITS-1:0]
                                           : rmag[SAMPLE_BITS-1:0];
        end
        n3_word.index_out = $signed(r2_index);
        if (r2_zero) begin
            n3_word.recon_out = '0;
        end else if (r2_neg) begin
            n3_word.recon_out = $signed(~rec_mag + 1'b1);
        end else begin
            n3_word.recon_out = $signed(rec_mag);
        end
        n3_word.last_out = r2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!st3_stall && r2_v) begin
            r3_word <= n3_word;
        end
    end

    assign o_valid = r3_v;
    assign o_word  = r3_word;

endmodule

// ===== hw/rtl/dead_zone_quantise_dequantise_unit.sv =====
// ============================================================================
// dead_zone_quantise_dequantise_unit
// Dead-zone quantiser / dequantiser for signed wavelet coefficients.
// ============================================================================
// One word enters per clock while the output side does not stall. A word
// passes through the sign/magnitude split, the restoring divider stages
// (three quotient bits per stage over an 18-bit dividend), and then index
// clamp, reconstruction multiply and round/clamp into the output register.
// Each stage holds only while it is full and the stage after it is blocked,
// so bubbles are squeezed out and the input keeps taking words while a
// finished word waits at the output, until every stage is full.
// Registers (step_x4, recon_ofs, op_mode) are written through the
// config channel, which is always ready; write them only while no words
// are in flight.
// ============================================================================
module dead_zone_quantise_dequantise_unit
    import dzq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_valid,
    input  t_in_word              i_word,
    output logic                  o_stall,
    // output words
    output logic                  o_valid,
    output t_out_word             o_word,
    input  logic                  i_stall,
    // register writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  fr_valid;
    t_side                 fr_side;
    logic                  fr_stall;
    logic                  dv_valid;
    t_side                 dv_side;
    logic [DIVIDEND_W-1:0] dv_quot;
    logic                  dv_stall;

    // Register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_x4   <= FACTOR_RESET;
            r_cfg.recon_ofs <= OFFSET_RESET;
            r_cfg.op_mode   <= MODE_QUANTISE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STEP_X4:   r_cfg.step_x4   <= i_cfg_data[FACTOR_W-1:0];
                CFG_RECON_OFS: r_cfg.recon_ofs <= i_cfg_data[OFFSET_W-1:0];
                CFG_OP_MODE:   r_cfg.op_mode   <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    dzq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_word    (i_word),
        .o_stall   (o_stall),
        .i_op_mode (r_cfg.op_mode),
        .o_valid   (fr_valid),
        .o_side    (fr_side),
        .i_stall   (fr_stall)
    );

    dzq_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fr_valid),
        .i_side   (fr_side),
        .o_stall  (fr_stall),
        .i_factor (r_cfg.step_x4),
        .o_valid  (dv_valid),
        .o_side   (dv_side),
        .o_quot   (dv_quot),
        .i_stall  (dv_stall)
    );

    dzq_recon u_recon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dv_valid),
        .i_side  (dv_side),
        .i_quot  (dv_quot),
        .o_stall (dv_stall),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_word  (o_word),
        .i_stall (i_stall)
    );

    // Input only backs up when the whole pipe is full and blocked
    a_stall_needs_full_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output side is free");

    // A zero index always reconstructs to zero
    a_zero_index_zero_recon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_word.index_out == '0)) |-> (o_word.recon_out == '0))
        else $error("nonzero reconstruction for zero index");

    // Nonzero reconstruction carries the index sign
    a_recon_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_word.recon_out != '0)) |->
            (o_word.recon_out[SAMPLE_BITS-1] == o_word.index_out[SAMPLE_BITS-1]))
        else $error("reconstruction sign differs from index sign");

endmodule
